// ----- hdl/acs_pkg.sv -----
// Shared types and constants for the anchor chain sweep unit.
// Used by acs_front, acs_queue, acs_back and anchor_chain_sweep_unit.
package acs_pkg;

    localparam int MAX_ANCHORS = 1024;
    localparam int ADDR_W      = $clog2(MAX_ANCHORS);
    localparam int ID_W        = 10;
    localparam int COORD_W     = 31;
    localparam int SCORE_W     = 32;
    localparam int PRIO_W      = 40;
    localparam int GAP_W       = 34;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic REG_SWEEP_END_X = 1'b0;
    localparam logic REG_SWEEP_END_Y = 1'b1;

    typedef struct packed {
        logic [1:0]               op;
        logic [ID_W-1:0]          anchor_id;
        logic [COORD_W-1:0]       pos_x;
        logic [COORD_W-1:0]       pos_y;
        logic signed [SCORE_W-1:0] weight;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]           result_id;
        logic                      has_pred;
        logic [ID_W-1:0]           pred_id;
        logic signed [SCORE_W-1:0] chain_score;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_QUERY  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                 kind;
        logic [ADDR_W-1:0]         id;
        logic [COORD_W-1:0]        pos_x;
        logic [COORD_W-1:0]        pos_y;
        logic signed [SCORE_W-1:0] weight;
        logic signed [GAP_W-1:0]   gap;
    } cmd_t;

    typedef struct packed {
        logic                      active;
        logic [COORD_W-1:0]        end_x;
        logic [COORD_W-1:0]        end_y;
        logic signed [PRIO_W-1:0]  prio;
    } rec_t;

    typedef struct packed {
        logic booting;
    } back_status_t;

endpackage

// ----- hdl/acs_front.sv -----
// Input side: sweep-end registers, item classification and gap cost.
// Depends on acs_pkg.
module acs_front
    import acs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  in_item_t     in_item,
    input  logic         cfg_we,
    input  logic         cfg_idx,
    input  logic [30:0]  cfg_data,
    input  back_status_t back_st,
    input  logic         q_full,
    output logic         q_push,
    output cmd_t         q_data
);

    logic [COORD_W-1:0] end_x_reg;
    logic [COORD_W-1:0] end_y_reg;
    logic               id_ok;
    logic               keep;
    logic [GAP_W-1:0]   gap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_x_reg <= '0;
            end_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == REG_SWEEP_END_X)
                end_x_reg <= cfg_data;
            if (cfg_idx == REG_SWEEP_END_Y)
                end_y_reg <= cfg_data;
        end
    end

    assign in_ready = !q_full && !back_st.booting;
    assign id_ok    = (32'(in_item.anchor_id) < MAX_ANCHORS);
    assign gap      = GAP_W'(end_x_reg) - GAP_W'(in_item.pos_x)
                    + GAP_W'(end_y_reg) - GAP_W'(in_item.pos_y);

    always_comb
    begin
        q_data.id     = ADDR_W'(in_item.anchor_id);
        q_data.pos_x  = in_item.pos_x;
        q_data.pos_y  = in_item.pos_y;
        q_data.weight = in_item.weight;
        q_data.gap    = $signed(gap);
        case (in_item.op)
            OP_BEGIN:
            begin
                q_data.kind = CMD_QUERY;
                keep        = id_ok;
            end
            OP_END:
            begin
                q_data.kind = CMD_INSERT;
                keep        = id_ok;
            end
            OP_CLEAR:
            begin
                q_data.kind = CMD_CLEAR;
                keep        = 1'b1;
            end
            default:
            begin
                // unused op: take the item and drop it
                q_data.kind = CMD_CLEAR;
                keep        = 1'b0;
            end
        endcase
    end

    assign q_push = in_valid && in_ready && keep;

endmodule

// ----- hdl/acs_queue.sv -----
// Short command queue between the front and the back of the sweep unit.
// Depends on acs_pkg.
module acs_queue
    import acs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    output logic pop_valid,
    input  logic pop,
    output cmd_t pop_data
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (!push && do_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- hdl/acs_back.sv -----
// Back end: entry table memories, scan sequencer, score update and result register.
// Depends on acs_pkg.
module acs_back
    import acs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  cmd_t         q_data,
    output logic         q_pop,
    output logic         out_valid,
    input  logic         out_ready,
    output out_item_t    out_item,
    output back_status_t back_st
);

    typedef enum logic [5:0] {
        S_WIPE  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_PRED  = 6'b001000,
        S_SCORE = 6'b010000,
        S_INS   = 6'b100000
    } state_t;

    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(MAX_ANCHORS - 1);

    rec_t                      rec_mem   [MAX_ANCHORS];
    logic signed [SCORE_W-1:0] score_mem [MAX_ANCHORS];

    state_t                    state_reg, state_next;
    logic [ADDR_W-1:0]         addr_reg, addr_next;
    logic                      issue_reg, issue_next;
    logic                      cmp_valid_reg, cmp_valid_next;
    logic [ADDR_W-1:0]         cmp_idx_reg, cmp_idx_next;
    logic                      found_reg, found_next;
    logic [ADDR_W-1:0]         best_reg, best_next;
    logic signed [PRIO_W-1:0]  best_prio_reg, best_prio_next;
    logic                      has_reg, has_next;
    logic                      boot_reg, boot_next;
    cmd_t                      cmd_reg, cmd_next;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_reg, out_next;

    rec_t                      rec_q;
    logic signed [SCORE_W-1:0] score_q;
    logic [ADDR_W-1:0]         score_raddr;

    logic                      rec_we;
    logic [ADDR_W-1:0]         rec_waddr;
    rec_t                      rec_wdata;
    logic                      score_we;
    logic [ADDR_W-1:0]         score_waddr;
    logic signed [SCORE_W-1:0] score_wdata;

    logic                      hit;
    logic signed [SCORE_W:0]   sum;
    logic signed [SCORE_W-1:0] sat_sum;
    logic signed [SCORE_W-1:0] new_score;
    logic                      out_free;

    assign score_raddr = (state_reg == S_IDLE) ? q_data.id : best_reg;

    always_ff @(posedge clk)
    begin
        rec_q   <= rec_mem[addr_reg];
        score_q <= score_mem[score_raddr];
        if (rec_we)
            rec_mem[rec_waddr] <= rec_wdata;
        if (score_we)
            score_mem[score_waddr] <= score_wdata;
    end

    assign hit = cmp_valid_reg && rec_q.active
              && (rec_q.end_x <= cmd_reg.pos_x) && (rec_q.end_y <= cmd_reg.pos_y)
              && (!found_reg || (rec_q.prio > best_prio_reg));

    assign sum     = (SCORE_W + 1)'(cmd_reg.weight) + (SCORE_W + 1)'(score_q);
    assign sat_sum = (sum[SCORE_W] != sum[SCORE_W-1])
                   ? {sum[SCORE_W], {(SCORE_W - 1){~sum[SCORE_W]}}}
                   : sum[SCORE_W-1:0];
    assign new_score = has_reg ? sat_sum : cmd_reg.weight;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_prio_next = best_prio_reg;
        has_next       = has_reg;
        boot_next      = boot_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        rec_we         = 1'b0;
        rec_waddr      = cmd_reg.id;
        rec_wdata      = '0;
        score_we       = 1'b0;
        score_waddr    = cmd_reg.id;
        score_wdata    = new_score;

        if (hit)
        begin
            found_next     = 1'b1;
            best_next      = cmp_idx_reg;
            best_prio_next = rec_q.prio;
        end

        case (state_reg)
            S_WIPE:
            begin
                rec_we      = 1'b1;
                rec_waddr   = addr_reg;
                score_we    = 1'b1;
                score_waddr = addr_reg;
                score_wdata = '0;
                if (addr_reg == LAST)
                begin
                    boot_next  = 1'b0;
                    state_next = S_IDLE;
                end
                else
                    addr_next = addr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data;
                    addr_next  = '0;
                    issue_next = 1'b1;
                    found_next = 1'b0;
                    best_next  = '0;
                    case (q_data.kind)
                        CMD_QUERY:  state_next = S_SCAN;
                        CMD_INSERT: state_next = S_INS;
                        CMD_CLEAR:  state_next = S_WIPE;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (issue_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = addr_reg;
                    if (addr_reg == LAST)
                        issue_next = 1'b0;
                    else
                        addr_next = addr_reg + 1'b1;
                end
                else if (cmp_valid_reg)
                    state_next = S_PRED;
            end
            S_PRED:
            begin
                // a self hit means no predecessor, no fallback to the runner-up
                has_next   = found_reg && (best_reg != cmd_reg.id);
                state_next = S_SCORE;
            end
            S_SCORE:
            begin
                if (out_free)
                begin
                    score_we              = 1'b1;
                    out_valid_next        = 1'b1;
                    out_next.result_id    = ID_W'(cmd_reg.id);
                    out_next.has_pred     = has_reg;
                    out_next.pred_id      = has_reg ? ID_W'(best_reg) : '0;
                    out_next.chain_score  = new_score;
                    state_next            = S_IDLE;
                end
            end
            S_INS:
            begin
                rec_we          = 1'b1;
                rec_wdata.active = 1'b1;
                rec_wdata.end_x = cmd_reg.pos_x;
                rec_wdata.end_y = cmd_reg.pos_y;
                rec_wdata.prio  = PRIO_W'(score_q) - PRIO_W'(cmd_reg.gap);
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_WIPE;
            addr_reg      <= '0;
            issue_reg     <= 1'b0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            has_reg       <= 1'b0;
            boot_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            has_reg       <= has_next;
            boot_reg      <= boot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        best_reg      <= best_next;
        best_prio_reg <= best_prio_next;
        cmd_reg       <= cmd_next;
        out_reg       <= out_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_item        = out_reg;
    assign back_st.booting = boot_reg;

endmodule

// ----- hdl/anchor_chain_sweep_unit.sv -----
// Anchor chain sweep unit: a begin item scans all MAX_ANCHORS table entries, one per cycle
// from the entry memory, before its result is registered on the output.
// The back end works on one begin, end or clear item at a time; a four-entry command queue
// decouples input. After reset the table is cleared entry by entry; in_ready stays low until
// it is done. Configuration writes are taken at any time.
module anchor_chain_sweep_unit
    import acs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item,
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [30:0] cfg_data
);

    back_status_t back_st;
    logic         q_full;
    logic         q_push;
    cmd_t         q_wdata;
    logic         q_valid;
    logic         q_pop;
    cmd_t         q_rdata;

    acs_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .back_st  (back_st),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    acs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_data  (q_rdata)
    );

    acs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .back_st   (back_st)
    );

endmodule

// ----- tb/sv/acs_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for anchor_chain_sweep_unit: watches the item, result and config ports.
// It predicts every chain result from its own anchor table and compares the results field by
// field. Depends on acs_pkg for the item types and table sizes.
module acs_checker
    import acs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_item_t    in_item,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_item_t   out_item,
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [30:0] cfg_data,
    output int          fail_count,
    output int          pending_count,
    output int          result_count,
    output int          link_count,
    output int          self_hit_count,
    output int          sat_count
);

    localparam longint SCORE_HI = 2147483647;
    localparam longint SCORE_LO = -SCORE_HI - 1;

    logic [COORD_W-1:0]        sweep_x;
    logic [COORD_W-1:0]        sweep_y;
    logic [COORD_W-1:0]        ent_end_x  [MAX_ANCHORS];
    logic [COORD_W-1:0]        ent_end_y  [MAX_ANCHORS];
    logic signed [PRIO_W-1:0]  ent_prio   [MAX_ANCHORS];
    logic signed [SCORE_W-1:0] ent_score  [MAX_ANCHORS];
    bit                        ent_active [MAX_ANCHORS];
    out_item_t                 chain_expect_q [$];

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    // Apply one accepted item to the table; a begin item also yields its chain result.
    task automatic chain_predict(input in_item_t it);
        longint    gap;
        longint    sum;
        int        best;
        bit        found;
        out_item_t res;
        found = 1'b0;
        best  = 0;
        if (it.op == OP_CLEAR)
        begin
            for (int i = 0; i < MAX_ANCHORS; i++)
            begin
                ent_active[i] = 1'b0;
                ent_score[i]  = '0;
            end
        end
        else if (int'(it.anchor_id) < MAX_ANCHORS && it.op == OP_END)
        begin
            gap = longint'(sweep_x) - longint'(it.pos_x) + longint'(sweep_y) - longint'(it.pos_y);
            ent_end_x[it.anchor_id]  = it.pos_x;
            ent_end_y[it.anchor_id]  = it.pos_y;
            ent_prio[it.anchor_id]   = PRIO_W'(longint'(ent_score[it.anchor_id]) - gap);
            ent_active[it.anchor_id] = 1'b1;
        end
        else if (int'(it.anchor_id) < MAX_ANCHORS && it.op == OP_BEGIN)
        begin
            // strict greater keeps the lowest index on equal priority
            for (int i = 0; i < MAX_ANCHORS; i++)
            begin
                if (ent_active[i] && ent_end_x[i] <= it.pos_x && ent_end_y[i] <= it.pos_y
                    && (!found || ent_prio[i] > ent_prio[best]))
                begin
                    found = 1'b1;
                    best  = i;
                end
            end
            res.result_id = it.anchor_id;
            res.has_pred  = found && (best != int'(it.anchor_id));
            res.pred_id   = res.has_pred ? ID_W'(best) : '0;
            if (res.has_pred)
            begin
                sum = longint'(it.weight) + longint'(ent_score[best]);
                if (sum > SCORE_HI || sum < SCORE_LO)
                    sat_count++;
                res.chain_score = (sum > SCORE_HI) ? SCORE_W'(SCORE_HI) :
                                  (sum < SCORE_LO) ? SCORE_W'(SCORE_LO) : SCORE_W'(sum);
                link_count++;
            end
            else
            begin
                res.chain_score = it.weight;
            end
            if (found && best == int'(it.anchor_id))
                self_hit_count++;
            ent_score[it.anchor_id] = res.chain_score;
            chain_expect_q = {chain_expect_q, res};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n)
        begin
            sweep_x = '0;
            sweep_y = '0;
            for (int i = 0; i < MAX_ANCHORS; i++)
            begin
                ent_active[i] = 1'b0;
                ent_score[i]  = '0;
            end
            chain_expect_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == REG_SWEEP_END_X)
                    sweep_x = cfg_data;
                else
                    sweep_y = cfg_data;
            end
            // check the result before queuing anything from this edge
            if (out_valid && out_ready)
            begin
                if (chain_expect_q.size() == 0)
                begin
                    flag_error($sformatf("result for anchor %0d with none expected",
                                         out_item.result_id));
                end
                else
                begin
                    want = chain_expect_q.pop_front();
                    result_count++;
                    if (out_item.result_id !== want.result_id)
                        flag_error($sformatf("result_id %0d, expected %0d",
                                             out_item.result_id, want.result_id));
                    if (out_item.has_pred !== want.has_pred)
                        flag_error($sformatf("anchor %0d: has_pred %0b, expected %0b",
                                             want.result_id, out_item.has_pred, want.has_pred));
                    if (out_item.pred_id !== want.pred_id)
                        flag_error($sformatf("anchor %0d: pred_id %0d, expected %0d",
                                             want.result_id, out_item.pred_id, want.pred_id));
                    if (out_item.chain_score !== want.chain_score)
                        flag_error($sformatf("anchor %0d: chain_score %0d, expected %0d",
                                             want.result_id, out_item.chain_score,
                                             want.chain_score));
                end
            end
            if (in_valid && in_ready)
                chain_predict(in_item);
        end
        pending_count = chain_expect_q.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top for anchor_chain_sweep_unit: clock, reset, sweep event stimulus, sweep end
// settings, result-side stalls and the verdict. Depends on acs_pkg, the unit and acs_checker.
module tb_top
    import acs_pkg::*;
();

    localparam logic [1:0]                OP_UNUSED   = 2'd3;
    localparam logic [COORD_W-1:0]        COORD_MAX   = '1;
    localparam logic signed [SCORE_W-1:0] WEIGHT_TOP  = 32'sh7FFF_FFFF;
    localparam logic signed [SCORE_W-1:0] WEIGHT_BOT  = 32'sh8000_0000;
    localparam int                        SETTLE_CYC  = (QUEUE_DEPTH + 1) * (MAX_ANCHORS + 8);
    localparam int                        CYCLE_LIMIT = 3_000_000;
    localparam int                        PHASE_ITEMS = 112;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    in_item_t      in_item;
    logic          out_valid;
    logic          out_ready;
    out_item_t     out_item;
    logic          cfg_we;
    logic          cfg_idx;
    logic [30:0]   cfg_data;

    int            fail_count;
    int            pending_count;
    int            result_count;
    int            link_count;
    int            self_hit_count;
    int            sat_count;
    int            items_sent;
    int            cfg_settings;
    int            cycle_count;
    int            stall_left;
    bit            idle_on;

    always #10 clk = ~clk;

    anchor_chain_sweep_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data)
    );

    acs_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending_count  (pending_count),
        .result_count   (result_count),
        .link_count     (link_count),
        .self_hit_count (self_hit_count),
        .sat_count      (sat_count)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_count);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // After each taken result, out_ready is dropped for a random stall while idling is on.
    always @(posedge clk)
    begin : result_side
        int hold;
        if (!rst_n)
        begin
            stall_left <= 0;
            out_ready  <= 1'b1;
        end
        else if (out_valid && out_ready)
        begin
            hold = idle_on ? $urandom_range(0, 3) : 0;
            stall_left <= hold;
            out_ready  <= (hold == 0);
        end
        else if (out_valid && stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= (stall_left == 1);
        end
    end

    function automatic in_item_t make_item(input logic [1:0] op,
                                           input logic [ID_W-1:0] id,
                                           input logic [COORD_W-1:0] x,
                                           input logic [COORD_W-1:0] y,
                                           input logic signed [SCORE_W-1:0] w);
        in_item_t it;
        it.op        = op;
        it.anchor_id = id;
        it.pos_x     = x;
        it.pos_y     = y;
        it.weight    = w;
        return it;
    endfunction

    function automatic logic signed [SCORE_W-1:0] draw_weight();
        if ($urandom_range(0, 19) == 0)
            return $urandom();
        return $urandom_range(0, 150) - 50;
    endfunction

    // Valid stays high between back-to-back items; drop it only for a drawn gap.
    task automatic send_item(input in_item_t it);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_sweep_end(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_SWEEP_END_X;
        cfg_data <= x;
        @(posedge clk);
        cfg_idx  <= REG_SWEEP_END_Y;
        cfg_data <= y;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cfg_settings++;
    endtask

    // Drain all results, then give queued end and clear items time to retire.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Mostly sweep-ordered begin/end pairs along a drifting diagonal, plus some noise.
    task automatic run_chain_phase(input int n_items);
        in_item_t           it;
        logic [ID_W-1:0]    open_id [$];
        logic [COORD_W-1:0] open_x  [$];
        logic [COORD_W-1:0] open_y  [$];
        logic [COORD_W-1:0] cur_x;
        logic [COORD_W-1:0] cur_y;
        int                 pool_base;
        int                 pool_size;
        int                 pick;
        int                 r;
        cur_x     = COORD_W'($urandom_range(64, 32'h7FFE_0000));
        cur_y     = COORD_W'($urandom_range(64, 32'h7FFE_0000));
        pool_base = $urandom_range(0, MAX_ANCHORS - 1);
        pool_size = $urandom_range(4, 48);
        for (int k = 0; k < n_items; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
            begin
                it = make_item(OP_CLEAR, ID_W'($urandom()), COORD_W'($urandom()),
                               COORD_W'($urandom()), $urandom());
            end
            else if (r < 5)
            begin
                it = make_item(OP_UNUSED, ID_W'($urandom()), COORD_W'($urandom()),
                               COORD_W'($urandom()), $urandom());
            end
            else if (r < 12)
            begin
                it = make_item(($urandom_range(0, 1) == 0) ? OP_BEGIN : OP_END,
                               ID_W'($urandom()), COORD_W'($urandom()),
                               COORD_W'($urandom()), $urandom());
            end
            else if (open_id.size() > 0 && (open_id.size() >= 6 || r < 56))
            begin
                pick = $urandom_range(0, open_id.size() - 1);
                it = make_item(OP_END, open_id[pick], open_x[pick], open_y[pick], $urandom());
                open_id.delete(pick);
                open_x.delete(pick);
                open_y.delete(pick);
            end
            else
            begin
                cur_x = cur_x + COORD_W'($urandom_range(0, 20));
                cur_y = cur_y + COORD_W'($urandom_range(0, 20));
                it = make_item(OP_BEGIN, ID_W'(pool_base + $urandom_range(0, pool_size - 1)),
                               cur_x, cur_y - COORD_W'($urandom_range(0, 8)), draw_weight());
                open_id = {open_id, it.anchor_id};
                open_x  = {open_x, it.pos_x + COORD_W'($urandom_range(0, 40))};
                open_y  = {open_y, it.pos_y + COORD_W'($urandom_range(0, 40))};
            end
            send_item(it);
        end
    endtask

    initial
    begin : stimulus
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_we    <= 1'b0;
        cfg_idx   <= REG_SWEEP_END_X;
        cfg_data  <= '0;
        idle_on    = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        write_sweep_end(31'd100, 31'd100);
        send_item(make_item(OP_BEGIN, 10'd0, 31'd0, 31'd0, 32'sd5));
        send_item(make_item(OP_END, 10'd0, 31'd10, 31'd10, 32'sd0));
        send_item(make_item(OP_BEGIN, 10'd1, 31'd20, 31'd20, 32'sd7));
        send_item(make_item(OP_END, 10'd1, 31'd30, 31'd30, 32'sd0));
        send_item(make_item(OP_BEGIN, 10'd2, 31'd25, 31'd25, 32'sd3));
        send_item(make_item(OP_END, 10'd2, 31'd30, 31'd30, 32'sd0));
        // anchor 4 ends with the same priority as anchor 1
        send_item(make_item(OP_BEGIN, 10'd4, 31'd20, 31'd20, 32'sd7));
        send_item(make_item(OP_END, 10'd4, 31'd30, 31'd30, 32'sd0));
        send_item(make_item(OP_BEGIN, 10'd5, 31'd40, 31'd40, 32'sd1));
        // anchor 6 ends first with the best priority, then hits itself
        send_item(make_item(OP_END, 10'd6, 31'd50, 31'd50, 32'sd0));
        send_item(make_item(OP_BEGIN, 10'd6, 31'd60, 31'd60, 32'sd9));
        send_item(make_item(OP_BEGIN, 10'd7, 31'd0, 31'd0, WEIGHT_TOP));
        send_item(make_item(OP_END, 10'd7, 31'd0, 31'd0, 32'sd0));
        send_item(make_item(OP_BEGIN, 10'd8, 31'd1, 31'd1, WEIGHT_TOP));
        send_item(make_item(OP_CLEAR, 10'd0, 31'd0, 31'd0, 32'sd0));
        send_item(make_item(OP_BEGIN, 10'd10, 31'd0, 31'd0, WEIGHT_BOT));
        send_item(make_item(OP_END, 10'd10, 31'd0, 31'd0, 32'sd0));
        send_item(make_item(OP_BEGIN, 10'd11, 31'd5, 31'd5, WEIGHT_BOT));
        send_item(make_item(OP_UNUSED, 10'd3, 31'd7, 31'd7, 32'sd1));
        send_item(make_item(OP_BEGIN, 10'd1023, COORD_MAX, COORD_MAX, -32'sd1));
        send_item(make_item(OP_END, 10'd1023, COORD_MAX, COORD_MAX, 32'sd0));
        send_item(make_item(OP_BEGIN, 10'd512, COORD_MAX, COORD_MAX, 32'sd0));
        settle();

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:       write_sweep_end('0, '0);
                1:       write_sweep_end(COORD_MAX, COORD_MAX);
                2:       write_sweep_end('0, COORD_MAX);
                default: write_sweep_end(COORD_W'($urandom()), COORD_W'($urandom()));
            endcase
            // one phase runs with no idling on either side
            idle_on = (p != 3);
            run_chain_phase(PHASE_ITEMS);
            settle();
        end

        $display("%0d items sent over %0d sweep end settings, %0d chain results checked",
                 items_sent, cfg_settings, result_count);
        $display("%0d results linked to a predecessor, %0d self hits, %0d saturated scores",
                 link_count, self_hit_count, sat_count);
        if (fail_count == 0 && pending_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
